@@ design/register_script_packetizer_assert.svh @@
// Assertion macros for the register script packetizer.
// Used by the top level; depends on nothing else.
`ifndef REGISTER_SCRIPT_PACKETIZER_ASSERT_SVH
`define REGISTER_SCRIPT_PACKETIZER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define RSP_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define RSP_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/rsp_pkg.sv @@
// Shared types, constants and decode functions of the register script packetizer.
// Depends on nothing; the interfaces, controller, datapath, top level and testbench use it.
package rsp_pkg;

  localparam int BUFFER_WORDS = 32;
  localparam int IDX_W = $clog2(BUFFER_WORDS);
  localparam int CNT_W = $clog2(BUFFER_WORDS + 1);
  localparam int SUM_W = CNT_W + 1;
  localparam int SIZE_W = 3;
  localparam int DATA_W = 32;
  localparam int CMD_W = 3;
  localparam int METHOD_W = 3;
  localparam int WCOUNT_W = 5;
  localparam int FBP_W = 5;
  localparam int CFG_IDX_W = 1;

  localparam logic [CNT_W-1:0] COUNT_MAX = CNT_W'(BUFFER_WORDS - 1);
  localparam logic [SUM_W-1:0] BUF_LIMIT = SUM_W'(BUFFER_WORDS);

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_WAR_DELAY = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FB_PARTS = 1'd1;

  // Script commands.
  localparam logic [CMD_W-1:0] CMD_WRITE = 3'd0;
  localparam logic [CMD_W-1:0] CMD_WAIT = 3'd1;
  localparam logic [CMD_W-1:0] CMD_DELAY = 3'd2;
  localparam logic [CMD_W-1:0] CMD_VBLANK = 3'd3;
  localparam logic [CMD_W-1:0] CMD_TRAIN = 3'd4;
  localparam logic [CMD_W-1:0] CMD_BLOCK = 3'd5;
  localparam logic [CMD_W-1:0] CMD_UNBLOCK = 3'd6;
  localparam logic [CMD_W-1:0] CMD_FLUSH = 3'd7;

  // Packet methods.
  localparam logic [METHOD_W-1:0] M_WRITE = 3'd0;
  localparam logic [METHOD_W-1:0] M_WAIT = 3'd1;
  localparam logic [METHOD_W-1:0] M_DELAY = 3'd2;
  localparam logic [METHOD_W-1:0] M_VBLANK = 3'd3;
  localparam logic [METHOD_W-1:0] M_TRAIN = 3'd4;
  localparam logic [METHOD_W-1:0] M_ENTER = 3'd5;
  localparam logic [METHOD_W-1:0] M_LEAVE = 3'd6;

  // Memory-controller workaround window and counted ranges.
  localparam logic [DATA_W-1:0] WIN_LO = 32'h0010_f000;
  localparam logic [DATA_W-1:0] WIN_HI = 32'h0011_0000;
  localparam logic [DATA_W-1:0] RNG0_LO = 32'h0010_f604;
  localparam logic [DATA_W-1:0] RNG0_HI = 32'h0010_f910;
  localparam logic [DATA_W-1:0] RNG1_LO = 32'h0010_fb04;
  localparam logic [DATA_W-1:0] RNG1_HI = 32'h0010_fe20;
  localparam logic [DATA_W-1:0] PART_REG_BASE = 32'h0013_d834;
  localparam int PART_STRIDE_SH = 6;

  // Which add is being built: the inserted partition write, the inserted
  // delay, or the command itself.
  typedef enum logic [1:0] {
    PH_WARW = 2'd0,
    PH_WARD = 2'd1,
    PH_MAIN = 2'd2
  } phase_t;

  typedef struct packed {
    logic   idle;
    logic   load;
    logic   war_eval;
    phase_t phase;
    logic   add_write;
    logic   add_commit;
    logic   emit_hdr;
    logic   emit_data;
    logic   flush_clear;
    logic   finish;
  } rsp_ctl_t;

  typedef struct packed {
    logic             war_insert;
    logic             prod_nonzero;
    logic             cmd_flush;
    logic             need_flush;
    logic             size_zero;
    logic             add_last;
    logic             flush_after;
    logic             pend_valid;
    logic             count_zero;
    logic             data_last;
    logic             emit_ok;
    logic             stage_v;
    logic [CNT_W-1:0] count;
  } rsp_stat_t;

  function automatic logic [METHOD_W-1:0] cmd_method(input logic [CMD_W-1:0] cmd);
    logic [METHOD_W-1:0] m;
    unique case (cmd)
      CMD_WRITE:   m = M_WRITE;
      CMD_WAIT:    m = M_WAIT;
      CMD_DELAY:   m = M_DELAY;
      CMD_VBLANK:  m = M_VBLANK;
      CMD_TRAIN:   m = M_TRAIN;
      CMD_BLOCK:   m = M_ENTER;
      CMD_UNBLOCK: m = M_LEAVE;
      default:     m = M_WRITE;
    endcase
    return m;
  endfunction

  function automatic logic [SIZE_W-1:0] cmd_size(input logic [CMD_W-1:0] cmd);
    logic [SIZE_W-1:0] s;
    unique case (cmd)
      CMD_WRITE:  s = 3'd2;
      CMD_WAIT:   s = 3'd4;
      CMD_DELAY:  s = 3'd1;
      CMD_VBLANK: s = 3'd1;
      default:    s = 3'd0;
    endcase
    return s;
  endfunction

  function automatic logic cmd_flushes(input logic [CMD_W-1:0] cmd);
    return (cmd == CMD_WAIT) || (cmd == CMD_DELAY) || (cmd == CMD_VBLANK);
  endfunction

endpackage

@@ design/rsp_ifs.sv @@
// Valid/ready channel interfaces for script commands and packet words.
// Depends on rsp_pkg for field widths.
interface rsp_cmd_if;
  logic                         valid;
  logic                         ready;
  logic [rsp_pkg::CMD_W-1:0]    cmd;
  logic [rsp_pkg::DATA_W-1:0]   reg_addr;
  logic [rsp_pkg::DATA_W-1:0]   reg_mask;
  logic [rsp_pkg::DATA_W-1:0]   reg_value;
  logic [rsp_pkg::DATA_W-1:0]   delay_ns;
  logic                         head_index;

  modport source(output valid, cmd, reg_addr, reg_mask, reg_value, delay_ns, head_index,
                 input ready);
  modport sink(input valid, cmd, reg_addr, reg_mask, reg_value, delay_ns, head_index,
               output ready);
endinterface

interface rsp_res_if;
  logic                           valid;
  logic                           ready;
  logic                           is_header;
  logic [rsp_pkg::METHOD_W-1:0]   method;
  logic [rsp_pkg::WCOUNT_W-1:0]   word_count;
  logic [rsp_pkg::DATA_W-1:0]     data_word;
  logic                           last;

  modport source(output valid, is_header, method, word_count, data_word, last,
                 input ready);
  modport sink(input valid, is_header, method, word_count, data_word, last,
               output ready);
endinterface

@@ design/rsp_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module rsp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ design/rsp_ctrl.sv @@
// Sequencing state machine of the register script packetizer.
// Depends on rsp_pkg; drives rsp_dp through rsp_ctl_t and reads rsp_stat_t.
module rsp_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  rsp_pkg::rsp_stat_t stat,
  output rsp_pkg::rsp_ctl_t  ctl
);

  typedef enum logic [8:0] {
    S_IDLE    = 9'b000000001,
    S_WAR     = 9'b000000010,
    S_ADD_CHK = 9'b000000100,
    S_ADD_WR  = 9'b000001000,
    S_COMMIT  = 9'b000010000,
    S_FL_HDR  = 9'b000100000,
    S_FL_DATA = 9'b001000000,
    S_NEXT    = 9'b010000000,
    S_FINISH  = 9'b100000000
  } state_t;

  state_t          state, state_next;
  rsp_pkg::phase_t phase, phase_next;
  logic            ret_add, ret_add_next;
  state_t          ret_state;
  state_t          main_state;

  assign ret_state  = ret_add ? S_ADD_CHK : S_NEXT;
  assign main_state = stat.cmd_flush ? S_FL_HDR : S_ADD_CHK;

  always_comb begin
    ctl            = '0;
    ctl.phase      = phase;
    state_next     = state;
    phase_next     = phase;
    ret_add_next   = ret_add;
    unique case (state)
      S_IDLE: begin
        ctl.idle = 1'b1;
        if (in_valid) begin
          ctl.load   = 1'b1;
          state_next = S_WAR;
        end
      end
      S_WAR: begin
        ctl.war_eval = 1'b1;
        if (stat.war_insert) begin
          phase_next = rsp_pkg::PH_WARW;
          state_next = S_ADD_CHK;
        end else begin
          phase_next   = rsp_pkg::PH_MAIN;
          ret_add_next = 1'b0;
          state_next   = main_state;
        end
      end
      S_ADD_CHK: begin
        if (stat.need_flush) begin
          ret_add_next = 1'b1;
          state_next   = S_FL_HDR;
        end else if (stat.size_zero) begin
          state_next = S_COMMIT;
        end else begin
          state_next = S_ADD_WR;
        end
      end
      S_ADD_WR: begin
        ctl.add_write = 1'b1;
        if (stat.add_last) begin
          state_next = S_COMMIT;
        end
      end
      S_COMMIT: begin
        ctl.add_commit = 1'b1;
        if (stat.flush_after) begin
          ret_add_next = 1'b0;
          state_next   = S_FL_HDR;
        end else begin
          state_next = S_NEXT;
        end
      end
      S_FL_HDR: begin
        if (!stat.pend_valid) begin
          state_next = ret_state;
        end else if (stat.emit_ok) begin
          ctl.emit_hdr = 1'b1;
          if (stat.count_zero) begin
            ctl.flush_clear = 1'b1;
            state_next      = ret_state;
          end else begin
            state_next = S_FL_DATA;
          end
        end
      end
      S_FL_DATA: begin
        if (stat.emit_ok) begin
          ctl.emit_data = 1'b1;
          if (stat.data_last) begin
            ctl.flush_clear = 1'b1;
            state_next      = ret_state;
          end
        end
      end
      S_NEXT: begin
        unique case (phase)
          rsp_pkg::PH_WARW: begin
            if (stat.prod_nonzero) begin
              phase_next = rsp_pkg::PH_WARD;
              state_next = S_ADD_CHK;
            end else begin
              phase_next   = rsp_pkg::PH_MAIN;
              ret_add_next = 1'b0;
              state_next   = main_state;
            end
          end
          rsp_pkg::PH_WARD: begin
            phase_next   = rsp_pkg::PH_MAIN;
            ret_add_next = 1'b0;
            state_next   = main_state;
          end
          default: begin
            state_next = S_FINISH;
          end
        endcase
      end
      S_FINISH: begin
        if (stat.emit_ok) begin
          ctl.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      phase   <= rsp_pkg::PH_MAIN;
      ret_add <= 1'b0;
    end else begin
      state   <= state_next;
      phase   <= phase_next;
      ret_add <= ret_add_next;
    end
  end

endmodule

@@ design/rsp_dp.sv @@
// Datapath of the register script packetizer: command latch, workaround counter,
// packet buffer, pending packet state and the two-deep result stage.
// Depends on rsp_pkg and rsp_ram.
module rsp_dp (
  input  logic                             clk,
  input  logic                             rst,
  input  rsp_pkg::rsp_ctl_t                ctl,
  output rsp_pkg::rsp_stat_t               stat,
  input  logic [rsp_pkg::CMD_W-1:0]        cmd,
  input  logic [rsp_pkg::DATA_W-1:0]       reg_addr,
  input  logic [rsp_pkg::DATA_W-1:0]       reg_mask,
  input  logic [rsp_pkg::DATA_W-1:0]       reg_value,
  input  logic [rsp_pkg::DATA_W-1:0]       delay_ns,
  input  logic                             head_index,
  input  logic                             cfg_we,
  input  logic [rsp_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [rsp_pkg::DATA_W-1:0]       cfg_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic                             out_is_header,
  output logic [rsp_pkg::METHOD_W-1:0]     out_method,
  output logic [rsp_pkg::WCOUNT_W-1:0]     out_word_count,
  output logic [rsp_pkg::DATA_W-1:0]       out_data_word,
  output logic                             out_last
);

  localparam int IDX_W = rsp_pkg::IDX_W;
  localparam int CNT_W = rsp_pkg::CNT_W;
  localparam int SUM_W = rsp_pkg::SUM_W;

  // Latched command.
  logic [rsp_pkg::CMD_W-1:0]  cmd_r;
  logic [rsp_pkg::DATA_W-1:0] addr_r, mask_r, value_r, ns_r;
  logic                       head_r;

  // Configuration.
  logic [rsp_pkg::DATA_W-1:0] war_delay;
  logic [rsp_pkg::FBP_W-1:0]  fb_parts;

  // Workaround state.
  logic [rsp_pkg::DATA_W-1:0] war_cnt;
  logic [rsp_pkg::DATA_W-1:0] prod;

  // Pending packet.
  logic [rsp_pkg::METHOD_W-1:0] pend_method;
  logic                         pend_valid;
  logic [CNT_W-1:0]             pend_count;
  logic [1:0]                   k;
  logic [IDX_W-1:0]             f;

  // Result stage and output register.
  logic                           stage_v;
  logic                           stage_hdr;
  logic [rsp_pkg::METHOD_W-1:0]   stage_method;
  logic [rsp_pkg::WCOUNT_W-1:0]   stage_wcount;
  logic [rsp_pkg::DATA_W-1:0]     stage_data;

  logic [rsp_pkg::DATA_W-1:0]   war_addr;
  logic                         in_win, in_rng, war_on, war_insert;
  logic [rsp_pkg::METHOD_W-1:0] add_method;
  logic [rsp_pkg::SIZE_W-1:0]   add_size;
  logic                         add_flush_after;
  logic [rsp_pkg::DATA_W-1:0]   add_word;
  logic [rsp_pkg::DATA_W-1:0]   rd_data;
  logic                         emit;
  logic                         emit_ok;
  logic                         new_hdr;
  logic [rsp_pkg::WCOUNT_W-1:0] new_wcount;
  logic [rsp_pkg::DATA_W-1:0]   new_data;

  assign war_addr = rsp_pkg::PART_REG_BASE
                  + ((rsp_pkg::DATA_W'(fb_parts) - 32'd1) << rsp_pkg::PART_STRIDE_SH);
  assign in_win = (addr_r >= rsp_pkg::WIN_LO) && (addr_r < rsp_pkg::WIN_HI);
  assign in_rng = ((addr_r >= rsp_pkg::RNG0_LO) && (addr_r < rsp_pkg::RNG0_HI))
               || ((addr_r >= rsp_pkg::RNG1_LO) && (addr_r < rsp_pkg::RNG1_HI));
  assign war_on = (war_delay != '0)
               && ((cmd_r == rsp_pkg::CMD_WRITE) || (cmd_r == rsp_pkg::CMD_WAIT));
  assign war_insert = war_on && !in_win && (war_cnt != '0);

  always_comb begin
    add_method      = rsp_pkg::cmd_method(cmd_r);
    add_size        = rsp_pkg::cmd_size(cmd_r);
    add_flush_after = rsp_pkg::cmd_flushes(cmd_r);
    add_word        = '0;
    unique case (ctl.phase)
      rsp_pkg::PH_WARW: begin
        add_method      = rsp_pkg::M_WRITE;
        add_size        = 3'd2;
        add_flush_after = 1'b0;
        add_word        = (k == 2'd0) ? war_addr : '0;
      end
      rsp_pkg::PH_WARD: begin
        add_method      = rsp_pkg::M_DELAY;
        add_size        = 3'd1;
        add_flush_after = 1'b1;
        add_word        = prod;
      end
      default: begin
        unique case (cmd_r)
          rsp_pkg::CMD_WRITE:  add_word = (k == 2'd0) ? addr_r : value_r;
          rsp_pkg::CMD_WAIT: begin
            unique case (k)
              2'd0:    add_word = addr_r;
              2'd1:    add_word = mask_r;
              2'd2:    add_word = value_r;
              default: add_word = ns_r;
            endcase
          end
          rsp_pkg::CMD_DELAY:  add_word = ns_r;
          rsp_pkg::CMD_VBLANK: add_word = rsp_pkg::DATA_W'(head_r);
          default:             add_word = '0;
        endcase
      end
    endcase
  end

  assign emit_ok = !stage_v || !out_valid || out_ready;

  assign stat.war_insert   = war_insert;
  assign stat.prod_nonzero = (prod != '0);
  assign stat.cmd_flush    = (cmd_r == rsp_pkg::CMD_FLUSH);
  assign stat.need_flush   = ((SUM_W'(pend_count) + SUM_W'(add_size)) >= rsp_pkg::BUF_LIMIT)
                          || (pend_valid && (pend_method != add_method));
  assign stat.size_zero    = (add_size == '0);
  assign stat.add_last     = (({1'b0, k} + 3'd1) == add_size);
  assign stat.flush_after  = add_flush_after;
  assign stat.pend_valid   = pend_valid;
  assign stat.count_zero   = (pend_count == '0);
  assign stat.data_last    = ((CNT_W'(f) + CNT_W'(1)) == pend_count);
  assign stat.emit_ok      = emit_ok;
  assign stat.stage_v      = stage_v;
  assign stat.count        = pend_count;

  rsp_ram #(
    .WIDTH(rsp_pkg::DATA_W),
    .DEPTH(rsp_pkg::BUFFER_WORDS)
  ) u_buf (
    .clk  (clk),
    .we   (ctl.add_write),
    .waddr(pend_count[IDX_W-1:0]),
    .wdata(add_word),
    .re   (ctl.emit_hdr || ctl.emit_data),
    .raddr(ctl.emit_hdr ? '0 : (f + IDX_W'(1))),
    .rdata(rd_data)
  );

  // Command latch and multiplier product.
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd_r   <= cmd;
      addr_r  <= reg_addr;
      mask_r  <= reg_mask;
      value_r <= reg_value;
      ns_r    <= delay_ns;
      head_r  <= head_index;
    end
    if (ctl.war_eval && war_insert) begin
      prod <= war_cnt * war_delay;
    end
  end

  // Configuration, workaround counter and pending packet.
  always_ff @(posedge clk) begin
    if (rst) begin
      war_delay   <= '0;
      fb_parts    <= rsp_pkg::FBP_W'(1);
      war_cnt     <= '0;
      pend_method <= rsp_pkg::M_WRITE;
      pend_valid  <= 1'b0;
      pend_count  <= '0;
      k           <= '0;
      f           <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          rsp_pkg::CFG_WAR_DELAY: war_delay <= cfg_data;
          default:                fb_parts  <= cfg_data[rsp_pkg::FBP_W-1:0];
        endcase
      end
      if (ctl.war_eval && war_on) begin
        if (in_win && in_rng) begin
          war_cnt <= war_cnt + 32'd1;
        end else if (war_insert) begin
          war_cnt <= '0;
        end
      end
      if (ctl.load) begin
        k <= '0;
      end
      if (ctl.add_write) begin
        pend_count <= pend_count + CNT_W'(1);
        k          <= k + 2'd1;
      end
      if (ctl.add_commit) begin
        pend_method <= add_method;
        pend_valid  <= 1'b1;
        k           <= '0;
      end
      if (ctl.emit_hdr) begin
        f <= '0;
      end
      if (ctl.emit_data) begin
        f <= f + IDX_W'(1);
      end
      if (ctl.flush_clear) begin
        pend_method <= rsp_pkg::M_WRITE;
        pend_valid  <= 1'b0;
        pend_count  <= '0;
      end
    end
  end

  // The newest word waits in the stage until the next one arrives or the
  // command ends; only then is it known whether it closes the command.
  assign emit       = ctl.emit_hdr || ctl.emit_data;
  assign new_hdr    = ctl.emit_hdr;
  assign new_wcount = ctl.emit_hdr ? rsp_pkg::WCOUNT_W'(pend_count) : '0;
  assign new_data   = ctl.emit_hdr ? '0 : rd_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_v   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (emit) begin
        stage_v <= 1'b1;
        if (stage_v) begin
          out_valid <= 1'b1;
        end
      end else if (ctl.finish && stage_v) begin
        stage_v   <= 1'b0;
        out_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      stage_hdr    <= new_hdr;
      stage_method <= pend_method;
      stage_wcount <= new_wcount;
      stage_data   <= new_data;
    end
    if ((emit || ctl.finish) && stage_v) begin
      out_is_header  <= stage_hdr;
      out_method     <= stage_method;
      out_word_count <= stage_wcount;
      out_data_word  <= stage_data;
      out_last       <= !emit;
    end
  end

endmodule

@@ design/register_script_packetizer.sv @@
// Top level of the register script packetizer: controller, datapath and ports.
// Depends on rsp_pkg, rsp_ifs, rsp_ctrl, rsp_dp and the assertion macro header.
//
//   Channel   Direction  Carries
//   cmd_chan  in         one script command per word (cmd, address, mask, value, ns, head)
//   res_chan  out        one packet word per word (header or data, with last marker)
//   cfg       in         register writes: war_delay_ns (0), fb_partitions (1)
//
// One command is taken at a time: accept and workaround check; per packet add a check,
// one buffer write per data word, a commit and a step state; per flush the header and
// each data word in turn (one RAM read each; an empty flush emits nothing); a closing step.
// Synchronous reset clears the control state, configuration, workaround counter, pending
// packet and valid flags, but not the buffer, command latch or stage data; unwritten buffer
// entries never reach the output. A stalled result side holds the sequence at its next word.

`include "register_script_packetizer_assert.svh"

module register_script_packetizer (
  input  logic                          clk,
  input  logic                          rst,
  rsp_cmd_if.sink                       cmd_chan,
  rsp_res_if.source                     res_chan,
  input  logic                          cfg_we,
  input  logic [rsp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rsp_pkg::DATA_W-1:0]    cfg_data
);

  rsp_pkg::rsp_ctl_t  ctl;
  rsp_pkg::rsp_stat_t stat;

  // The controller walks each command through its steps: an optional
  // workaround partition write and delay, then the command's own add,
  // with flushes wherever the method changes, the buffer would fill, or the command calls for one.
  rsp_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(cmd_chan.valid),
    .stat    (stat),
    .ctl     (ctl)
  );

  // Commands are taken only while the controller is idle.
  assign cmd_chan.ready = ctl.idle;

  // The datapath holds the latched command, the buffer and the result stage.
  rsp_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .ctl           (ctl),
    .stat          (stat),
    .cmd           (cmd_chan.cmd),
    .reg_addr      (cmd_chan.reg_addr),
    .reg_mask      (cmd_chan.reg_mask),
    .reg_value     (cmd_chan.reg_value),
    .delay_ns      (cmd_chan.delay_ns),
    .head_index    (cmd_chan.head_index),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .out_valid     (res_chan.valid),
    .out_ready     (res_chan.ready),
    .out_is_header (res_chan.is_header),
    .out_method    (res_chan.method),
    .out_word_count(res_chan.word_count),
    .out_data_word (res_chan.data_word),
    .out_last      (res_chan.last)
  );

  // When the block is ready for a command, no word of the previous one may
  // still sit in the stage, or its last marker would be lost.
  `RSP_ASSERT_IMP(a_idle_stage_empty, clk, rst, cmd_chan.ready, !stat.stage_v, "stage busy while idle")

  // An accepted command takes the controller out of idle, so ready drops after the accept.
  `RSP_ASSERT_NXT(a_busy_after_accept, clk, rst, cmd_chan.valid && cmd_chan.ready, !cmd_chan.ready, "ready right after accept")

  // The pending packet never fills the whole buffer.
  `RSP_ASSERT_IMP(a_count_bound, clk, rst, 1'b1, stat.count <= rsp_pkg::COUNT_MAX, "pending count overflow")

  // A word is emitted only when the stage can take it.
  `RSP_ASSERT_IMP(a_emit_room, clk, rst, ctl.emit_hdr || ctl.emit_data, stat.emit_ok, "emit without room")

endmodule

@@ tb/register_script_packetizer_tb.sv @@
// Self-checking testbench for the register script packetizer: drives script commands,
// writes the workaround registers between phases and checks every packet word.
// Depends on rsp_pkg, the rsp_cmd_if/rsp_res_if interfaces and the packetizer RTL.
`timescale 1ns / 1ps

module register_script_packetizer_tb;
  import rsp_pkg::*;

  // A run ends as failed when this many cycles pass without any word moving.
  localparam int STALL_LIMIT = 2000;
  // A command can be absorbed into the open packet without producing a word, so
  // the block may still be busy after the last expected word; this covers its
  // longest command sequence with margin.
  localparam int IDLE_PAUSE = 80;
  localparam int ITEMS_PER_PHASE = 47;
  localparam int NUM_PHASES = 5;
  localparam logic [DATA_W-1:0] PART_STRIDE = 32'h40;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [DATA_W-1:0] reg_addr;
    logic [DATA_W-1:0] reg_mask;
    logic [DATA_W-1:0] reg_value;
    logic [DATA_W-1:0] delay_ns;
    logic              head_index;
  } cmd_word_t;

  typedef struct packed {
    logic                is_header;
    logic [METHOD_W-1:0] method;
    logic [WCOUNT_W-1:0] word_count;
    logic [DATA_W-1:0]   data_word;
    logic                last;
  } packet_word_t;

  // The scoreboard carries its own copy of the packet buffer, the workaround
  // counter and both registers. Each accepted command is turned into the packet
  // words it releases, and those are queued in order for the result side.
  class packetizer_scoreboard;
    packet_word_t        expected_words[$];
    packet_word_t        step_words[$];
    int                  errors;
    logic [DATA_W-1:0]   war_ns;
    logic [FBP_W-1:0]    partitions;
    logic [METHOD_W-1:0] open_method;
    bit                  open_valid;
    int unsigned         open_count;
    logic [DATA_W-1:0]   open_words[BUFFER_WORDS];
    logic [DATA_W-1:0]   mc_hits;

    function new();
      errors = 0;
      war_ns = '0;
      partitions = 5'd1;
      open_method = M_WRITE;
      open_valid = 1'b0;
      open_count = 0;
      mc_hits = '0;
    endfunction

    function void set_register(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] val);
      if (idx == CFG_WAR_DELAY) begin
        war_ns = val;
      end else if (idx == CFG_FB_PARTS) begin
        partitions = val[FBP_W-1:0];
      end
    endfunction

    function void close_packet();
      packet_word_t w;
      int unsigned i;
      if (!open_valid) return;
      w.is_header = 1'b1;
      w.method = open_method;
      w.word_count = WCOUNT_W'(open_count);
      w.data_word = '0;
      w.last = 1'b0;
      step_words.push_back(w);
      for (i = 0; i < open_count; i++) begin
        w.is_header = 1'b0;
        w.word_count = '0;
        w.data_word = open_words[i];
        step_words.push_back(w);
      end
      open_valid = 1'b0;
      open_method = M_WRITE;
      open_count = 0;
    endfunction

    // Merge a command's words into the open packet, closing it first when the
    // method differs or the buffer would fill up.
    function void merge_words(logic [METHOD_W-1:0] method, int unsigned size,
                              logic [DATA_W-1:0] words[4]);
      int unsigned i;
      if (open_count + size >= BUFFER_WORDS || (open_valid && open_method != method))
        close_packet();
      for (i = 0; i < size && open_count < BUFFER_WORDS; i++) begin
        open_words[open_count] = words[i];
        open_count++;
      end
      open_method = method;
      open_valid = 1'b1;
    endfunction

    // Count accesses to the two memory-controller ranges; the first access
    // outside the window pays them off with a partition write and, unless it is zero, a delay.
    function void mc_workaround(logic [DATA_W-1:0] addr);
      logic [DATA_W-1:0] hits;
      logic [DATA_W-1:0] product;
      logic [DATA_W-1:0] w[4];
      if (war_ns == '0) return;
      if (addr >= WIN_LO && addr < WIN_HI) begin
        if ((addr >= RNG0_LO && addr < RNG0_HI) || (addr >= RNG1_LO && addr < RNG1_HI))
          mc_hits++;
        return;
      end
      if (mc_hits == '0) return;
      hits = mc_hits;
      mc_hits = '0;
      // The partition register lies outside the window, so this write cannot
      // trigger a second payoff.
      w[0] = PART_REG_BASE + (DATA_W'(partitions) - 32'd1) * PART_STRIDE;
      w[1] = '0;
      w[2] = '0;
      w[3] = '0;
      merge_words(M_WRITE, 2, w);
      product = hits * war_ns;
      if (product != '0) begin
        w[0] = product;
        merge_words(M_DELAY, 1, w);
        close_packet();
      end
    endfunction

    function void note_command(cmd_word_t c);
      logic [DATA_W-1:0] w[4];
      packet_word_t pw;
      int i;
      step_words.delete();
      w[0] = '0;
      w[1] = '0;
      w[2] = '0;
      w[3] = '0;
      case (c.cmd)
        CMD_WRITE: begin
          mc_workaround(c.reg_addr);
          w[0] = c.reg_addr;
          w[1] = c.reg_value;
          merge_words(M_WRITE, 2, w);
        end
        CMD_WAIT: begin
          mc_workaround(c.reg_addr);
          w[0] = c.reg_addr;
          w[1] = c.reg_mask;
          w[2] = c.reg_value;
          w[3] = c.delay_ns;
          merge_words(M_WAIT, 4, w);
          close_packet();
        end
        CMD_DELAY: begin
          w[0] = c.delay_ns;
          merge_words(M_DELAY, 1, w);
          close_packet();
        end
        CMD_VBLANK: begin
          w[0] = {31'b0, c.head_index};
          merge_words(M_VBLANK, 1, w);
          close_packet();
        end
        CMD_TRAIN: merge_words(M_TRAIN, 0, w);
        CMD_BLOCK: merge_words(M_ENTER, 0, w);
        CMD_UNBLOCK: merge_words(M_LEAVE, 0, w);
        default: close_packet();
      endcase
      for (i = 0; i < step_words.size(); i++) begin
        pw = step_words[i];
        pw.last = (i == step_words.size() - 1);
        expected_words.push_back(pw);
      end
    endfunction

    function void compare_field(string name, logic [DATA_W-1:0] want, logic [DATA_W-1:0] got);
      if (want !== got) begin
        $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_word(packet_word_t got);
      packet_word_t want;
      if (expected_words.size() == 0) begin
        $display("%0t: unexpected word, expected none actual hdr=%0b m=%0d n=%0d d=%h l=%0b",
                 $time, got.is_header, got.method, got.word_count, got.data_word, got.last);
        errors++;
        return;
      end
      want = expected_words.pop_front();
      compare_field("is_header", DATA_W'(want.is_header), DATA_W'(got.is_header));
      compare_field("method", DATA_W'(want.method), DATA_W'(got.method));
      compare_field("word_count", DATA_W'(want.word_count), DATA_W'(got.word_count));
      compare_field("data_word", want.data_word, got.data_word);
      compare_field("last", DATA_W'(want.last), DATA_W'(got.last));
    endfunction

    function int pending();
      return expected_words.size();
    endfunction
  endclass

  logic                 clk;
  logic                 rst;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [DATA_W-1:0]    cfg_data;

  rsp_cmd_if cmd_if();
  rsp_res_if res_if();

  packetizer_scoreboard sb;

  // Sender burst state and the receiver's stall pattern.
  int          burst_left;
  logic [15:0] stall_bits;
  int          pattern_age;

  register_script_packetizer uut (
    .clk(clk),
    .rst(rst),
    .cmd_chan(cmd_if),
    .res_chan(res_if),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Observe every handshake at the clock edge. Values read here are those that
  // were settled before the edge, so ordering inside the time step does not
  // matter. Register writes only happen while the block is idle, so updating
  // the predictor's copy here keeps it in step with the block.
  always @(posedge clk) begin : observe
    packet_word_t got;
    cmd_word_t c;
    if (!rst) begin
      if (cfg_we) sb.set_register(cfg_index, cfg_data);
      if (cmd_if.valid && cmd_if.ready) begin
        c.cmd = cmd_if.cmd;
        c.reg_addr = cmd_if.reg_addr;
        c.reg_mask = cmd_if.reg_mask;
        c.reg_value = cmd_if.reg_value;
        c.delay_ns = cmd_if.delay_ns;
        c.head_index = cmd_if.head_index;
        sb.note_command(c);
      end
      if (res_if.valid && res_if.ready) begin
        got.is_header = res_if.is_header;
        got.method = res_if.method;
        got.word_count = res_if.word_count;
        got.data_word = res_if.data_word;
        got.last = res_if.last;
        sb.check_word(got);
      end
    end
  end

  // The receiver follows a rotating 16-bit pattern, reloaded when its random age
  // count runs out: sometimes never stalling, sometimes lightly or heavily stalled,
  // and sometimes with long stretches of back-pressure.
  always @(posedge clk) begin
    res_if.ready <= stall_bits[0];
    if (pattern_age == 0) begin
      pattern_age <= $urandom_range(16, 96);
      case ($urandom_range(0, 3))
        0: stall_bits <= 16'hffff;
        1: stall_bits <= 16'($urandom) | 16'($urandom);
        2: stall_bits <= 16'($urandom);
        default: stall_bits <= 16'h0001;
      endcase
    end else begin
      pattern_age <= pattern_age - 1;
      stall_bits <= {stall_bits[0], stall_bits[15:1]};
    end
  end

  // Give up when no word moves on either channel for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (cmd_if.valid && cmd_if.ready) || (res_if.valid && res_if.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("register_script_packetizer_tb: done, errors");
    $finish;
  end

  function automatic cmd_word_t make_cmd(logic [CMD_W-1:0] cmd, logic [DATA_W-1:0] addr,
                                         logic [DATA_W-1:0] mask, logic [DATA_W-1:0] value,
                                         logic [DATA_W-1:0] ns, logic head);
    cmd_word_t c;
    c.cmd = cmd;
    c.reg_addr = addr;
    c.reg_mask = mask;
    c.reg_value = value;
    c.delay_ns = ns;
    c.head_index = head;
    return c;
  endfunction

  function automatic logic [DATA_W-1:0] pick_data();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return $urandom;
    endcase
  endfunction

  // An address inside one of the two counted memory-controller ranges.
  function automatic logic [DATA_W-1:0] counted_addr();
    if ($urandom_range(0, 1) == 0)
      return RNG0_LO + $urandom_range(0, RNG0_HI - RNG0_LO - 1);
    return RNG1_LO + $urandom_range(0, RNG1_HI - RNG1_LO - 1);
  endfunction

  // An address outside the workaround window.
  function automatic logic [DATA_W-1:0] outside_addr();
    if ($urandom_range(0, 1) == 0) return $urandom_range(0, WIN_LO - 1);
    return $urandom | 32'h0100_0000;
  endfunction

  // Addresses lean toward the workaround window and its boundaries.
  function automatic logic [DATA_W-1:0] pick_addr();
    case ($urandom_range(0, 9))
      0, 1, 2: return counted_addr();
      3: return WIN_LO + $urandom_range(0, WIN_HI - WIN_LO - 1);
      4: begin
        case ($urandom_range(0, 10))
          0: return RNG0_LO;
          1: return RNG0_HI - 1;
          2: return RNG0_HI;
          3: return RNG1_LO - 1;
          4: return RNG1_LO;
          5: return RNG1_HI - 1;
          6: return RNG1_HI;
          7: return WIN_LO - 1;
          8: return WIN_LO;
          9: return WIN_HI - 1;
          default: return WIN_HI;
        endcase
      end
      5, 6, 7: return $urandom;
      8: return '0;
      default: return '1;
    endcase
  endfunction

  function automatic cmd_word_t random_cmd(logic [CMD_W-1:0] op, logic [DATA_W-1:0] addr);
    return make_cmd(op, addr, pick_data(), pick_data(), pick_data(), 1'($urandom));
  endfunction

  // Offer one command and return at the edge where it is taken. The sender works
  // in bursts; between bursts it usually drops valid for a random gap, but now
  // and then it runs straight into the next burst.
  task automatic send_command(input cmd_word_t c);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
      if (gap > 0) begin
        cmd_if.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    cmd_if.valid <= 1'b1;
    cmd_if.cmd <= c.cmd;
    cmd_if.reg_addr <= c.reg_addr;
    cmd_if.reg_mask <= c.reg_mask;
    cmd_if.reg_value <= c.reg_value;
    cmd_if.delay_ns <= c.delay_ns;
    cmd_if.head_index <= c.head_index;
    do @(posedge clk); while (!cmd_if.ready);
  endtask

  // Stop sending, let every expected word arrive, then allow for a command
  // that is still being absorbed without producing a word.
  task automatic settle_block();
    cmd_if.valid <= 1'b0;
    burst_left = 0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (IDLE_PAUSE) @(posedge clk);
  endtask

  // Both registers are written on consecutive edges so that the write
  // enable only rises and falls once.
  task automatic apply_settings(input logic [DATA_W-1:0] delay_val,
                                input logic [FBP_W-1:0] parts_val);
    cfg_we <= 1'b1;
    cfg_index <= CFG_WAR_DELAY;
    cfg_data <= delay_val;
    @(posedge clk);
    cfg_index <= CFG_FB_PARTS;
    cfg_data <= DATA_W'(parts_val);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Random traffic. Most of it is shaped: runs of writes that merge into one
  // packet and can hit the buffer limit, runs of zero-word commands that merge, and
  // counted accesses followed by an outside access that pays off the workaround.
  task automatic random_phase(input int items);
    int sent;
    int run;
    int i;
    logic [CMD_W-1:0] op;
    sent = 0;
    while (sent < items) begin
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          run = $urandom_range(1, 18);
          for (i = 0; i < run; i++) send_command(random_cmd(CMD_WRITE, pick_addr()));
          sent += run;
        end
        3: begin
          op = CMD_W'($urandom_range(CMD_TRAIN, CMD_UNBLOCK));
          run = $urandom_range(1, 5);
          for (i = 0; i < run; i++) send_command(random_cmd(op, pick_addr()));
          sent += run;
        end
        4, 5: begin
          run = $urandom_range(1, 6);
          for (i = 0; i < run; i++) begin
            op = ($urandom_range(0, 3) == 0) ? CMD_WAIT : CMD_WRITE;
            send_command(random_cmd(op, counted_addr()));
          end
          op = ($urandom_range(0, 3) == 0) ? CMD_WAIT : CMD_WRITE;
          send_command(random_cmd(op, outside_addr()));
          sent += run + 1;
        end
        default: begin
          send_command(random_cmd(CMD_W'($urandom_range(0, 7)), pick_addr()));
          sent++;
        end
      endcase
    end
  endtask

  initial begin
    logic [DATA_W-1:0] phase_ns[NUM_PHASES];
    logic [FBP_W-1:0]  phase_parts[NUM_PHASES];
    int p;

    sb = new();
    clk = 1'b0;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = CFG_WAR_DELAY;
    cfg_data = '0;
    cmd_if.valid = 1'b0;
    cmd_if.cmd = CMD_FLUSH;
    cmd_if.reg_addr = '0;
    cmd_if.reg_mask = '0;
    cmd_if.reg_value = '0;
    cmd_if.delay_ns = '0;
    cmd_if.head_index = 1'b0;
    res_if.ready = 1'b0;
    stall_bits = 16'hffff;
    pattern_age = 0;
    burst_left = 0;

    // Register settings of the random phases: the smallest delay with zero
    // partitions (the partition address wraps), the largest delay with the
    // widest partition field, a delay whose product with an even count wraps
    // to zero, a random enabled setting, and the workaround switched off.
    phase_ns[0] = 32'd1;
    phase_parts[0] = 5'd0;
    phase_ns[1] = 32'hffff_ffff;
    phase_parts[1] = 5'd31;
    phase_ns[2] = 32'h8000_0000;
    phase_parts[2] = 5'd1;
    phase_ns[3] = $urandom_range(1, 32'hffff_ffff);
    phase_parts[3] = FBP_W'($urandom_range(1, 16));
    phase_ns[4] = '0;
    phase_parts[4] = FBP_W'($urandom_range(0, 31));

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed part under the reset settings (workaround off). A flush of an
    // empty buffer comes first and must produce nothing.
    send_command(make_cmd(CMD_FLUSH, '0, '0, '0, '0, 1'b0));
    send_command(make_cmd(CMD_WRITE, '0, '0, '0, '0, 1'b0));
    send_command(make_cmd(CMD_WRITE, '1, '1, '1, '1, 1'b1));
    send_command(make_cmd(CMD_WAIT, RNG0_LO, '1, '0, '1, 1'b0));
    send_command(make_cmd(CMD_DELAY, '0, '0, '0, '0, 1'b0));
    send_command(make_cmd(CMD_DELAY, '0, '0, '0, '1, 1'b0));
    send_command(make_cmd(CMD_VBLANK, '0, '0, '0, '0, 1'b0));
    send_command(make_cmd(CMD_VBLANK, '1, '1, '1, '1, 1'b1));
    // Repeated zero-word commands of one kind merge into one packet with no data words.
    send_command(make_cmd(CMD_TRAIN, '0, '0, '0, '0, 1'b0));
    send_command(make_cmd(CMD_TRAIN, '0, '0, '0, '0, 1'b0));
    send_command(make_cmd(CMD_BLOCK, '0, '0, '0, '0, 1'b0));
    send_command(make_cmd(CMD_BLOCK, '0, '0, '0, '0, 1'b0));
    send_command(make_cmd(CMD_UNBLOCK, '0, '0, '0, '0, 1'b0));
    send_command(make_cmd(CMD_FLUSH, '0, '0, '0, '0, 1'b0));
    send_command(make_cmd(CMD_FLUSH, '0, '0, '0, '0, 1'b0));
    send_command(make_cmd(CMD_WRITE, 32'h1234_5678, '0, 32'h9abc_def0, '0, 1'b0));
    send_command(make_cmd(CMD_TRAIN, '0, '0, '0, '0, 1'b0));
    settle_block();

    // Directed workaround: counted writes and a wait at the range edges, an
    // uncounted access inside the window, then an outside write pays them off.
    apply_settings(32'd3, 5'd16);
    send_command(make_cmd(CMD_WRITE, RNG0_LO, '0, 32'h1, '0, 1'b0));
    send_command(make_cmd(CMD_WRITE, RNG1_HI - 1, '0, 32'h2, '0, 1'b0));
    send_command(make_cmd(CMD_WAIT, RNG1_LO, '1, 32'h3, 32'd100, 1'b0));
    send_command(make_cmd(CMD_WRITE, WIN_LO, '0, 32'h4, '0, 1'b0));
    send_command(make_cmd(CMD_WRITE, 32'h0020_0000, '0, 32'h5, '0, 1'b0));
    send_command(make_cmd(CMD_FLUSH, '0, '0, '0, '0, 1'b0));
    settle_block();

    for (p = 0; p < NUM_PHASES; p++) begin
      apply_settings(phase_ns[p], phase_parts[p]);
      random_phase(ITEMS_PER_PHASE);
      settle_block();
    end

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("register_script_packetizer_tb: done, clean");
    end else begin
      $display("register_script_packetizer_tb: done, errors");
    end
    $finish;
  end

endmodule
